FILE: rtl/shifted_copy_interference_macros.svh
// Assertion macros used by the checker of the shifted copy interference block.
`ifndef SHIFTED_COPY_INTERFERENCE_MACROS_SVH
`define SHIFTED_COPY_INTERFERENCE_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low.
`define SCI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define SCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sci_pkg.sv
// Shared constants and types of the shifted copy interference block.
package sci_pkg;

    localparam int POINT_LIMIT = 8;
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int X_W    = 9;
    localparam int Y_W    = 9;
    localparam int PIX_W  = 24;
    localparam int ADDR_W = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
    localparam int PT_W   = (POINT_LIMIT > 1) ? $clog2(POINT_LIMIT) : 1;
    localparam int CNT_W  = $clog2(POINT_LIMIT + 1);
    localparam int ACC_W  = $clog2(POINT_LIMIT * 255 + 1);
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_POINT_COUNT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_OFFSETS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_Y_OFFSETS    = 3'd2;
    localparam logic [IDX_W-1:0] REG_ALPHA        = 3'd3;
    localparam logic [IDX_W-1:0] REG_RGB_SPLIT    = 3'd4;
    localparam logic [IDX_W-1:0] REG_BLEND_MODE   = 3'd5;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

    // blend codes
    localparam logic [1:0] BLEND_REPLACE = 2'd0;
    localparam logic [1:0] BLEND_ADD     = 2'd1;

    // action codes
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

endpackage

FILE: rtl/sci_frame_store.sv
// Frame store memory: one write port, one registered read port.
module sci_frame_store (
    input  logic                            aclk,
    input  sci_pkg::store_wr_t              wr,
    input  sci_pkg::store_rd_t              rd,
    output logic [sci_pkg::PIX_W-1:0]       rd_data
);

    localparam int DEPTH = sci_pkg::MAX_WIDTH * sci_pkg::MAX_HEIGHT;

    logic [sci_pkg::PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

FILE: rtl/shifted_copy_interference.sv
// Top level of the shifted copy interference block: sequencer, scaler and blend.
//
//  channel  | ports                       | fields (lowest bit up)
//  ---------+-----------------------------+--------------------------------------------
//  input    | s_tvalid s_tready s_tdata   | tdata: pixel_x, pixel_y, pixel_value
//           | s_tuser                     | tuser: action (0 write, 1 request)
//  result   | m_tvalid m_tready m_tdata   | tdata: out_pixel
//  config   | cfg_wr_en cfg_index         | cfg_wr_data: register value, low bits used
//
//  A write transfer goes straight to the frame store. A request runs from its transfer to
//  the next free input slot through n point steps, n being the clamped point count (0 to
//  8): one frame-store read per in-frame point and one for the stored pixel, all through
//  the single read port, then the blend step and the output register load.
//  Reset (aresetn low, synchronous) clears the sequencer and output valid and loads the
//  register reset values; the frame store is not cleared and holds garbage until written.
//  A stalled result waits in the output register; the next item is still taken.
module shifted_copy_interference (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pixel_x[8:0], pixel_y[17:9], pixel_value[41:18]
    input  logic        s_tuser,   // action[0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_pixel[23:0]
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [sci_pkg::IDX_W-1:0]      cfg_index,
    input  logic [sci_pkg::CFG_W-1:0]      cfg_wr_data
);

    localparam int ACC_W = sci_pkg::ACC_W;
    localparam int CNT_W = sci_pkg::CNT_W;
    localparam int PT_W  = sci_pkg::PT_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_POINT  = 5'b00010,
        ST_STORED = 5'b00100,
        ST_BLEND  = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    // floor(a*v/255) for a 16-bit product: (p + 1 + p/256) / 256
    function automatic logic [7:0] scale255(input logic [7:0] a, input logic [7:0] v);
        logic [15:0] p;
        logic [16:0] s;
        p = 16'(a) * 16'(v);
        s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return s[15:8];
    endfunction

    // ---------------- configuration registers ----------------
    logic [3:0]  point_count_reg;
    logic [63:0] x_offsets_reg;
    logic [63:0] y_offsets_reg;
    logic [7:0]  alpha_reg;
    logic        rgb_split_reg;
    logic [1:0]  blend_mode_reg;
    logic [9:0]  frame_width_reg;
    logic [9:0]  frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg  <= 4'd2;
            x_offsets_reg    <= '0;
            y_offsets_reg    <= '0;
            alpha_reg        <= 8'd128;
            rgb_split_reg    <= 1'b1;
            blend_mode_reg   <= sci_pkg::BLEND_REPLACE;
            frame_width_reg  <= 10'd512;
            frame_height_reg <= 10'd512;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sci_pkg::REG_POINT_COUNT:  point_count_reg  <= cfg_wr_data[3:0];
                sci_pkg::REG_X_OFFSETS:    x_offsets_reg    <= cfg_wr_data;
                sci_pkg::REG_Y_OFFSETS:    y_offsets_reg    <= cfg_wr_data;
                sci_pkg::REG_ALPHA:        alpha_reg        <= cfg_wr_data[7:0];
                sci_pkg::REG_RGB_SPLIT:    rgb_split_reg    <= cfg_wr_data[0];
                sci_pkg::REG_BLEND_MODE:   blend_mode_reg   <= cfg_wr_data[1:0];
                sci_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data[9:0];
                sci_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[9:0];
                default: ;
            endcase
        end
    end

    // ---------------- input unpacking ----------------
    logic [8:0]  in_x;
    logic [8:0]  in_y;
    logic [23:0] in_value;
    logic        s_accept;

    assign in_x     = s_tdata[8:0];
    assign in_y     = s_tdata[17:9];
    assign in_value = s_tdata[41:18];

    // ---------------- sequencer state ----------------
    state_t            state_reg, state_next;
    logic [8:0]        x_reg, x_next;
    logic [8:0]        y_reg, y_next;
    logic [CNT_W-1:0]  n_reg, n_next;           // clamped point count
    logic [9:0]        w_reg, w_next;           // clamped frame size
    logic [9:0]        h_reg, h_next;
    logic              split_reg, split_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;       // point under read
    logic [1:0]        mod3_reg, mod3_next;     // idx mod 3
    logic              pend_reg, pend_next;     // point data arrives this cycle
    logic [1:0]        pend_c_reg, pend_c_next; // its channel in split mode
    logic [ACC_W-1:0]  ch_reg [3];
    logic [ACC_W-1:0]  ch_next [3];
    logic [23:0]       res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic [23:0]       m_data_reg, m_data_next;

    sci_pkg::store_wr_t        st_wr;
    sci_pkg::store_rd_t        st_rd;
    logic [sci_pkg::PIX_W-1:0] st_rd_data;

    sci_frame_store u_store (
        .aclk    (aclk),
        .wr      (st_wr),
        .rd      (st_rd),
        .rd_data (st_rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // writes go straight to the store
    assign st_wr.en   = s_accept && (s_tuser == sci_pkg::ACT_WRITE);
    assign st_wr.addr = {in_y, in_x};
    assign st_wr.data = in_value;

    // source coordinate of the current point
    logic [PT_W-1:0]   cur_pt;
    logic signed [7:0] dx, dy;
    logic signed [10:0] sx, sy;
    logic              in_frame;
    logic [CNT_W-1:0]  n_clamp;
    logic [CNT_W-1:0]  idx_inc;

    assign cur_pt   = idx_reg[PT_W-1:0];
    assign dx       = x_offsets_reg[{cur_pt, 3'b000} +: 8];
    assign dy       = y_offsets_reg[{cur_pt, 3'b000} +: 8];
    assign sx       = $signed({2'b00, x_reg}) - 11'(dx);
    assign sy       = $signed({2'b00, y_reg}) - 11'(dy);
    assign in_frame = !sx[10] && !sy[10] && (sx[9:0] < w_reg) && (sy[9:0] < h_reg);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign n_clamp  = (point_count_reg > 4'(sci_pkg::POINT_LIMIT))
                    ? CNT_W'(sci_pkg::POINT_LIMIT) : CNT_W'(point_count_reg);

    // blend lanes
    logic [7:0] sat_a [3];
    logic [7:0] st_b  [3];
    logic [8:0] add_ab [3];
    logic [7:0] blended [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sat_a[c]  = (ch_reg[c] > ACC_W'(255)) ? 8'd255 : ch_reg[c][7:0];
            st_b[c]   = st_rd_data[8*c +: 8];
            add_ab[c] = {1'b0, sat_a[c]} + {1'b0, st_b[c]};
            case (blend_mode_reg)
                sci_pkg::BLEND_REPLACE: blended[c] = sat_a[c];
                sci_pkg::BLEND_ADD:     blended[c] = add_ab[c][8] ? 8'd255 : add_ab[c][7:0];
                default:                blended[c] = {1'b0, sat_a[c][7:1]} + {1'b0, st_b[c][7:1]};
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        n_next       = n_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        split_next   = split_reg;
        idx_next     = idx_reg;
        mod3_next    = mod3_reg;
        pend_next    = 1'b0;
        pend_c_next  = pend_c_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        st_rd.en     = 1'b0;
        st_rd.addr   = {sy[8:0], sx[8:0]};
        for (int c = 0; c < 3; c++) begin
            ch_next[c] = ch_reg[c];
        end

        // shared scaler: fold in the point read issued last cycle
        if (pend_reg) begin
            for (int c = 0; c < 3; c++) begin
                if (!split_reg || (pend_c_reg == 2'(c))) begin
                    ch_next[c] = ch_reg[c] + ACC_W'(scale255(alpha_reg, st_rd_data[8*c +: 8]));
                end
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser == sci_pkg::ACT_REQUEST)) begin
                    x_next     = in_x;
                    y_next     = in_y;
                    n_next     = n_clamp;
                    w_next     = (frame_width_reg > 10'(sci_pkg::MAX_WIDTH))
                               ? 10'(sci_pkg::MAX_WIDTH) : frame_width_reg;
                    h_next     = (frame_height_reg > 10'(sci_pkg::MAX_HEIGHT))
                               ? 10'(sci_pkg::MAX_HEIGHT) : frame_height_reg;
                    split_next = rgb_split_reg
                               && ((n_clamp == CNT_W'(3)) || (n_clamp == CNT_W'(6)));
                    idx_next   = '0;
                    mod3_next  = 2'd0;
                    for (int c = 0; c < 3; c++) begin
                        ch_next[c] = '0;
                    end
                    state_next = (n_clamp == '0) ? ST_STORED : ST_POINT;
                end
            end
            ST_POINT: begin
                st_rd.en    = in_frame;
                pend_next   = in_frame;
                pend_c_next = mod3_reg;
                idx_next    = idx_inc;
                mod3_next   = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                if (idx_inc == n_reg) begin
                    state_next = ST_STORED;
                end
            end
            ST_STORED: begin
                // last point folds in while the stored pixel is read
                st_rd.en   = 1'b1;
                st_rd.addr = {y_reg, x_reg};
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                res_next   = {blended[2], blended[1], blended[0]};
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        n_reg      <= n_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        split_reg  <= split_next;
        idx_reg    <= idx_next;
        mod3_reg   <= mod3_next;
        pend_c_reg <= pend_c_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        for (int c = 0; c < 3; c++) begin
            ch_reg[c] <= ch_next[c];
        end
    end

endmodule

FILE: rtl/sci_checker.sv
// Port-level checker for the shifted copy interference block, bound to the top level.
`include "shifted_copy_interference_macros.svh"

module sci_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    `SCI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `SCI_ASSERT_NEXT(a_write_silent, aclk, aresetn, s_tvalid && s_tready && (s_tuser == sci_pkg::ACT_WRITE) && !m_tvalid, !m_tvalid, "write transfer produced a result")
    `SCI_ASSERT_NEXT(a_request_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser == sci_pkg::ACT_REQUEST), !s_tready, "input ready right after a request")
    `SCI_ASSERT_NEXT(a_reset_clear, aclk, 1'b1, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind shifted_copy_interference sci_checker u_sci_checker (.*);
